### hw/rtl/tcpf_pkg.sv
package tcpf_pkg;

   // fixed point format of the stored probabilities
   localparam int FRAC_BITS = 30;
   localparam int PROB_W    = FRAC_BITS + 1;
   localparam int OPND_W    = 32;
   localparam int PROD_W    = 64;
   localparam int MULR_W    = PROB_W + OPND_W;
   localparam int OP_W      = 2;
   localparam int CLASS_W   = 2;
   localparam int NCLASS    = 3;

   // step counter covers the quotient bits of the divider
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'((64'd1 << FRAC_BITS) / 3);
   localparam logic [PROD_W-1:0] FLOOR_UNIT = PROD_W'(64'd1 << FRAC_BITS);

   // op codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // class codes
   localparam logic [CLASS_W-1:0] CLASS_PERSON  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_VEHICLE = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_OTHER   = 2'd2;

   typedef struct packed {
      logic capture;    // take the request beat into the datapath
      logic mul_en;     // multiply the head operands and rotate
      logic acc_en;     // floor the product, push it, add it to the sum
      logic div_en;     // one quotient bit in every lane
      logic div_first;  // first quotient bit, no shift
      logic commit;     // store the quotients as the new probabilities
      logic out_load;   // load the response registers
   } cmd_type;

   typedef struct packed {
      logic update;     // captured op changes the probabilities
   } sts_type;

endpackage

### hw/rtl/three_class_probability_fusion_unit.sv
// Three-class probability fusion (person, vehicle, other). The unit holds three
// class probabilities in unsigned Q1.30, one third each after reset. A request beat
// with op 0 loads three new values, op 1 multiplies the held probabilities by three
// evidence factors, op 2 (and the unused op 3) only reads. For ops 0 and 1 each
// product is raised to a floor of 2^-30, the three are summed and each is divided
// by the sum, truncated to Q1.30. Every request gives one response beat with the
// three probabilities after the step and the one picked by query_class (zero for
// class code 3). An update goes from acceptance to the response register through
// op decode, the shared 31x32 multiplier and sum adder, the three restoring divider
// lanes (one quotient bit per cycle), the store of the quotients and the response
// load, which waits while a stalled beat holds that register. A read goes from op
// decode to the response load. The unit works on one request at a time; a new one is
// taken once the previous result sits in the response register, even if stalled.
module three_class_probability_fusion_unit
   import tcpf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [OPND_W-1:0]   req_factor_person,
   input  logic [OPND_W-1:0]   req_factor_vehicle,
   input  logic [OPND_W-1:0]   req_factor_other,
   input  logic [CLASS_W-1:0]  req_query_class,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PROB_W-1:0]   rsp_prob_person,
   output logic [PROB_W-1:0]   rsp_prob_vehicle,
   output logic [PROB_W-1:0]   rsp_prob_other,
   output logic [PROB_W-1:0]   rsp_selected_probability
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: op decode, multiply, divide, commit, response hand-off
   tcpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // probability state, multiplier, sum, divider lanes and response registers
   tcpf_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .sts                      (sts),
      .req_op                   (req_op),
      .req_factor_person        (req_factor_person),
      .req_factor_vehicle       (req_factor_vehicle),
      .req_factor_other         (req_factor_other),
      .req_query_class          (req_query_class),
      .rsp_prob_person          (rsp_prob_person),
      .rsp_prob_vehicle         (rsp_prob_vehicle),
      .rsp_prob_other           (rsp_prob_other),
      .rsp_selected_probability (rsp_selected_probability)
   );

endmodule

### hw/rtl/tcpf_ctrl.sv
module tcpf_ctrl
   import tcpf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NCLASS);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in   = '0;
            state_in = sts.update ? ST_MUL : ST_FINISH;
         end
         ST_MUL: begin
            cmd.mul_en = (cnt_ff != MUL_LAST);
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_DIV: begin
            cmd.div_en    = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_COMMIT;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response register overwritten while stalled");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHECK))
      else $error("accepted beat not followed by op check");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> (state_ff == ST_COMMIT))
      else $error("divider did not hand over to commit");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count out of range");

endmodule

### hw/rtl/tcpf_datapath.sv
module tcpf_datapath
   import tcpf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [OP_W-1:0]     req_op,
   input  logic [OPND_W-1:0]   req_factor_person,
   input  logic [OPND_W-1:0]   req_factor_vehicle,
   input  logic [OPND_W-1:0]   req_factor_other,
   input  logic [CLASS_W-1:0]  req_query_class,
   output logic [PROB_W-1:0]   rsp_prob_person,
   output logic [PROB_W-1:0]   rsp_prob_vehicle,
   output logic [PROB_W-1:0]   rsp_prob_other,
   output logic [PROB_W-1:0]   rsp_selected_probability
);

   logic [OP_W-1:0]    op_ff;
   logic [CLASS_W-1:0] query_ff;
   logic [OPND_W-1:0]  opnd_ff [NCLASS];
   logic [OPND_W-1:0]  opnd_in [NCLASS];
   logic [PROB_W-1:0]  prob_ff [NCLASS];
   logic [PROB_W-1:0]  prob_in [NCLASS];
   logic [PROD_W-1:0]  mul_ff, mul_in;
   logic [MULR_W-1:0]  mul_raw;
   logic [PROD_W-1:0]  floored;
   logic [PROD_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0]  rem_ff [NCLASS];
   logic [PROD_W-1:0]  rem_in [NCLASS];
   logic [PROB_W-1:0]  q_ff [NCLASS];
   logic [PROB_W-1:0]  q_in [NCLASS];
   logic [PROD_W:0]    trial [NCLASS];
   logic [PROD_W:0]    diff [NCLASS];
   logic               ge [NCLASS];
   logic [PROB_W-1:0]  sel_prob;

   assign sts.update = op_ff inside {OP_LOAD, OP_UPDATE};

   // head of the rotating operand ring
   assign mul_raw = prob_ff[0] * opnd_ff[0];
   assign mul_in  = (op_ff == OP_LOAD) ? (PROD_W'(opnd_ff[0]) << FRAC_BITS)
                                       : PROD_W'(mul_raw);
   assign floored = (mul_ff < FLOOR_UNIT) ? FLOOR_UNIT : mul_ff;
   assign sum_in  = cmd.capture ? '0 : (cmd.acc_en ? sum_ff + floored : sum_ff);

   always_comb begin
      for (int k = 0; k < NCLASS; k++) begin
         opnd_in[k] = opnd_ff[k];
         prob_in[k] = prob_ff[k];
         rem_in[k]  = rem_ff[k];
         q_in[k]    = q_ff[k];
         trial[k]   = cmd.div_first ? {1'b0, rem_ff[k]} : {rem_ff[k], 1'b0};
         diff[k]    = trial[k] - {1'b0, sum_ff};
         ge[k]      = (trial[k] >= {1'b0, sum_ff});
      end
      if (cmd.capture) begin
         opnd_in[0] = req_factor_person;
         opnd_in[1] = req_factor_vehicle;
         opnd_in[2] = req_factor_other;
      end else if (cmd.mul_en) begin
         for (int k = 0; k < NCLASS; k++) begin
            opnd_in[k] = opnd_ff[(k + 1) % NCLASS];
            prob_in[k] = prob_ff[(k + 1) % NCLASS];
         end
      end
      if (cmd.acc_en) begin
         for (int k = 0; k < NCLASS - 1; k++) begin
            rem_in[k] = rem_ff[k + 1];
         end
         rem_in[NCLASS-1] = floored;
      end else if (cmd.div_en) begin
         for (int k = 0; k < NCLASS; k++) begin
            rem_in[k] = ge[k] ? diff[k][PROD_W-1:0] : trial[k][PROD_W-1:0];
            q_in[k]   = cmd.div_first ? PROB_W'(ge[k]) : {q_ff[k][PROB_W-2:0], ge[k]};
         end
      end
      if (cmd.commit) begin
         for (int k = 0; k < NCLASS; k++) begin
            prob_in[k] = q_ff[k];
         end
      end
   end

   always_comb begin
      case (query_ff)
         CLASS_PERSON:  sel_prob = prob_ff[0];
         CLASS_VEHICLE: sel_prob = prob_ff[1];
         CLASS_OTHER:   sel_prob = prob_ff[2];
         default:       sel_prob = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NCLASS; k++) begin
            prob_ff[k] <= PROB_RESET;
         end
      end else begin
         prob_ff <= prob_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         query_ff <= req_query_class;
      end
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sum_ff  <= sum_in;
      mul_ff  <= mul_in;
      if (cmd.out_load) begin
         rsp_prob_person          <= prob_ff[0];
         rsp_prob_vehicle         <= prob_ff[1];
         rsp_prob_other           <= prob_ff[2];
         rsp_selected_probability <= sel_prob;
      end
   end

endmodule
